// File: rtl/fmss_pkg.sv
// Shared constants, widths and control structs of the factorization machine score core.
`timescale 1ns / 1ps
`default_nettype none
package fmss_pkg;

  // Number of factor fields carried by one node, and the number of them in use.
  localparam int unsigned LANES     = 8;
  localparam int unsigned DIM       = 8;
  // Nodes per sample that the accumulators hold without wrapping.
  localparam int unsigned MAX_NODES = 256;

  // Field and accumulator widths.
  localparam int unsigned IN_W   = 16;
  localparam int unsigned FRAC_W = 12;
  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned PROD_W = 2 * IN_W;
  localparam int unsigned SUM_W  = IN_W + NODE_W;
  localparam int unsigned SQR_W  = PROD_W - 1 + NODE_W;
  localparam int unsigned TERM_W = 2 * SUM_W;
  localparam int unsigned L1_W   = TERM_W + 1;
  localparam int unsigned L2_W   = TERM_W + 2;
  localparam int unsigned L3_W   = TERM_W + 3;
  localparam int unsigned HALF_W = L3_W - 1;
  localparam int unsigned WSC_W  = SUM_W + FRAC_W;
  localparam int unsigned TOT_W  = HALF_W + 1;
  localparam int unsigned OUT_W  = 48;

  // Register stages from the snapshot of a finished sample to the output register.
  localparam int unsigned NSTAGE = 6;

  // Control of one lane for the current cycle.
  typedef struct packed {
    logic acc;
    logic last;
    logic load_term;
  } lane_ctrl_t;

  // Load enables of the merging stage registers.
  typedef struct packed {
    logic load_w2;
    logic load_s3;
    logic load_s4;
    logic load_s5;
    logic load_out;
  } merge_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/fmss_node_if.sv
// Stream interface that carries one feature node request.
`timescale 1ns / 1ps
`default_nettype none
interface fmss_node_if;
  import fmss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  node_weight;
  logic signed [IN_W-1:0]  factor_0;
  logic signed [IN_W-1:0]  factor_1;
  logic signed [IN_W-1:0]  factor_2;
  logic signed [IN_W-1:0]  factor_3;
  logic signed [IN_W-1:0]  factor_4;
  logic signed [IN_W-1:0]  factor_5;
  logic signed [IN_W-1:0]  factor_6;
  logic signed [IN_W-1:0]  factor_7;
  logic                    last_node;

  modport source (
    output valid, node_weight, factor_0, factor_1, factor_2, factor_3,
           factor_4, factor_5, factor_6, factor_7, last_node,
    input  ready
  );

  modport sink (
    input  valid, node_weight, factor_0, factor_1, factor_2, factor_3,
           factor_4, factor_5, factor_6, factor_7, last_node,
    output ready
  );

endinterface
`default_nettype wire

// File: rtl/fmss_score_if.sv
// Stream interface that carries one sample score request.
`timescale 1ns / 1ps
`default_nettype none
interface fmss_score_if;
  import fmss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] score;

  modport source (
    output valid, score,
    input  ready
  );

  modport sink (
    input  valid, score,
    output ready
  );

endinterface
`default_nettype wire

// File: rtl/fmss_lane.sv
// One factor lane: running sum and sum of squares, sample snapshot and pair term.
`timescale 1ns / 1ps
`default_nettype none
module fmss_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fmss_pkg::lane_ctrl_t              ctrl_i,
  input  logic signed [fmss_pkg::IN_W-1:0]  factor_i,
  output logic signed [fmss_pkg::TERM_W-1:0] term_o
);
  import fmss_pkg::*;

  logic signed [SUM_W-1:0]  fsum_q, fsum_d;
  logic [SQR_W-1:0]         ssum_q, ssum_d;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  snap_sum_q;
  logic [SQR_W-1:0]         snap_sqr_q;
  logic signed [TERM_W-1:0] sum_sq;
  logic signed [TERM_W-1:0] term_d, term_q;

  // Accumulate the factor and its square; both wrap at their width.
  always_comb begin
    prod   = factor_i * factor_i;
    fsum_d = fsum_q + SUM_W'(factor_i);
    ssum_d = ssum_q + SQR_W'(unsigned'(prod));
  end

  // Accumulators restart from zero after the last node of a sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsum_q <= '0;
      ssum_q <= '0;
    end else if (ctrl_i.acc) begin
      if (ctrl_i.last) begin
        fsum_q <= '0;
        ssum_q <= '0;
      end else begin
        fsum_q <= fsum_d;
        ssum_q <= ssum_d;
      end
    end
  end

  // Snapshot of the finished sample, including its last node.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc && ctrl_i.last) begin
      snap_sum_q <= fsum_d;
      snap_sqr_q <= ssum_d;
    end
  end

  // Pair term of this lane: sum squared minus sum of squares.
  always_comb begin
    sum_sq = snap_sum_q * snap_sum_q;
    term_d = sum_sq - signed'(TERM_W'(snap_sqr_q));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_term) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule
`default_nettype wire

// File: rtl/fmss_merge.sv
// Merging stage: adder tree over the lane terms, halving, weight add and saturation.
`timescale 1ns / 1ps
`default_nettype none
module fmss_merge (
  input  logic                               clk_i,
  input  fmss_pkg::merge_ctrl_t              ctrl_i,
  input  logic signed [fmss_pkg::TERM_W-1:0] term_i [fmss_pkg::LANES],
  input  logic signed [fmss_pkg::SUM_W-1:0]  weight_i,
  output logic signed [fmss_pkg::OUT_W-1:0]  score_o
);
  import fmss_pkg::*;

  localparam logic signed [OUT_W-1:0] OutMax = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OutMin = {1'b1, {(OUT_W - 1){1'b0}}};

  logic signed [SUM_W-1:0]  w2_q, w3_q, w4_q, w5_q;
  logic signed [L1_W-1:0]   s3_d [4];
  logic signed [L1_W-1:0]   s3_q [4];
  logic signed [L2_W-1:0]   s4_d [2];
  logic signed [L2_W-1:0]   s4_q [2];
  logic signed [L3_W-1:0]   s5_d, s5_q;
  logic signed [HALF_W-1:0] half;
  logic signed [WSC_W-1:0]  w_scaled;
  logic signed [TOT_W-1:0]  total;
  logic                     fits;
  logic signed [OUT_W-1:0]  score_d, score_q;

  // Registered adder tree, one level per stage.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s3_d[i] = L1_W'(term_i[2 * i]) + L1_W'(term_i[2 * i + 1]);
    end
    for (int i = 0; i < 2; i++) begin
      s4_d[i] = L2_W'(s3_q[2 * i]) + L2_W'(s3_q[2 * i + 1]);
    end
    s5_d = L3_W'(s4_q[0]) + L3_W'(s4_q[1]);
  end

  // Halve with rounding toward minus infinity, add the scaled weight sum and saturate.
  always_comb begin
    half     = HALF_W'(s5_q >>> 1);
    w_scaled = {w5_q, {FRAC_W{1'b0}}};
    total    = TOT_W'(w_scaled) + TOT_W'(half);
    fits     = (&total[TOT_W-1:OUT_W-1]) || !(|total[TOT_W-1:OUT_W-1]);
    if (fits) begin
      score_d = total[OUT_W-1:0];
    end else if (total[TOT_W-1]) begin
      score_d = OutMin;
    end else begin
      score_d = OutMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_w2) begin
      w2_q <= weight_i;
    end
    if (ctrl_i.load_s3) begin
      w3_q <= w2_q;
      s3_q <= s3_d;
    end
    if (ctrl_i.load_s4) begin
      w4_q <= w3_q;
      s4_q <= s4_d;
    end
    if (ctrl_i.load_s5) begin
      w5_q <= w4_q;
      s5_q <= s5_d;
    end
    if (ctrl_i.load_out) begin
      score_q <= score_d;
    end
  end

  assign score_o = score_q;

endmodule
`default_nettype wire

// File: rtl/fm_second_order_score_core.sv
// Top level of the second-order factorization machine score core.
//
// The node channel takes one feature node request per cycle: a Q4.12 linear
// weight, eight Q4.12 latent factors and a flag that marks the sample's last
// node. Eight lanes accumulate the factor sums and sums of squares side by
// side while the weight sum is kept here. A node without the flag produces no
// result. On the last node the lanes hand their totals to a six-stage
// pipeline (lane snapshot, pair term multiply, three adder tree levels, then
// the weight add with saturation), and the score channel presents the Q.24
// score from the output register. Throughput is one node per cycle while
// node ready is high, also across sample boundaries; the pair term
// multiplier in each lane and the adder tree levels are registered.
// When the score receiver stalls, the pipeline keeps taking nodes until every
// stage holds a finished sample; only then does node ready drop.
// Reset clears all accumulators and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module fm_second_order_score_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  fmss_node_if.sink    node_i,
  fmss_score_if.source score_o
);
  import fmss_pkg::*;

  logic signed [IN_W-1:0]   factor [LANES];
  logic signed [TERM_W-1:0] term [LANES];
  logic [NSTAGE-1:0]        v_q, v_d, free, load;
  logic                     in_fire, head;
  logic signed [SUM_W-1:0]  wsum_q, wsum_d, w1_q;
  lane_ctrl_t               lane_ctrl;
  merge_ctrl_t              merge_ctrl;

  assign factor[0] = node_i.factor_0;
  assign factor[1] = node_i.factor_1;
  assign factor[2] = node_i.factor_2;
  assign factor[3] = node_i.factor_3;
  assign factor[4] = node_i.factor_4;
  assign factor[5] = node_i.factor_5;
  assign factor[6] = node_i.factor_6;
  assign factor[7] = node_i.factor_7;

  // A stage can load when it is empty or its content moves on.
  always_comb begin
    free[NSTAGE-1] = !v_q[NSTAGE-1] || score_o.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      free[k] = !v_q[k] || free[k + 1];
    end
  end

  assign node_i.ready = free[0];
  assign in_fire      = node_i.valid && free[0];
  assign head         = in_fire && node_i.last_node;

  // Valid bits and load enables of the result pipeline.
  always_comb begin
    v_d[0]  = free[0] ? head : v_q[0];
    load[0] = head;
    for (int k = 1; k < NSTAGE; k++) begin
      v_d[k]  = free[k] ? v_q[k - 1] : v_q[k];
      load[k] = free[k] && v_q[k - 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Running weight sum, cleared after the last node of a sample.
  assign wsum_d = wsum_q + SUM_W'(node_i.node_weight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsum_q <= '0;
    end else if (in_fire) begin
      wsum_q <= node_i.last_node ? '0 : wsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      w1_q <= wsum_d;
    end
  end

  always_comb begin
    lane_ctrl.acc       = in_fire;
    lane_ctrl.last      = node_i.last_node;
    lane_ctrl.load_term = load[1];
    merge_ctrl.load_w2  = load[1];
    merge_ctrl.load_s3  = load[2];
    merge_ctrl.load_s4  = load[3];
    merge_ctrl.load_s5  = load[4];
    merge_ctrl.load_out = load[5];
  end

  // Factor lanes; lanes beyond the configured dimension contribute nothing.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    if (l < DIM) begin : g_used
      fmss_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (lane_ctrl),
        .factor_i (factor[l]),
        .term_o   (term[l])
      );
    end else begin : g_unused
      assign term[l] = '0;
    end
  end

  fmss_merge u_merge (
    .clk_i    (clk_i),
    .ctrl_i   (merge_ctrl),
    .term_i   (term),
    .weight_i (w1_q),
    .score_o  (score_o.score)
  );

  assign score_o.valid = v_q[NSTAGE-1];

endmodule
`default_nettype wire

// File: rtl/fmss_checker.sv
// Port-level checker of the score core and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fmss_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              in_last_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [fmss_pkg::OUT_W-1:0] out_score_i
);
  import fmss_pkg::*;

  logic [3:0] pend_q;

  // Samples whose last node was taken but whose score was not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_valid_i && in_ready_i && in_last_i)
                       - 4'(out_valid_i && out_ready_i);
    end
  end

  // A stalled score request holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_score_i))
    else $error("score request changed while stalled");

  // Node ready drops only under score backpressure.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("node ready low without score backpressure");

  // Every score belongs to a finished sample.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 4'd0)
    else $error("score without a finished sample");

  // No more samples in flight than pipeline stages.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'(NSTAGE))
    else $error("more samples in flight than pipeline stages");

endmodule

bind fm_second_order_score_core fmss_checker u_fmss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (node_i.valid),
  .in_ready_i  (node_i.ready),
  .in_last_i   (node_i.last_node),
  .out_valid_i (score_o.valid),
  .out_ready_i (score_o.ready),
  .out_score_i (score_o.score)
);
`default_nettype wire

// File: sim/fm_second_order_score_checker.sv
// Score checker: watches both channels, predicts each sample score and compares.
`timescale 1ns / 1ps
module fm_second_order_score_checker
  import fmss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fmss_node_if        node_i,
  fmss_score_if       score_i,
  output int unsigned fail_count_o,
  output int unsigned scores_due_o
);

  localparam longint SCORE_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam longint SCORE_MIN = -SCORE_MAX - 64'sd1;

  // Running sums of the sample in progress.
  logic signed [SUM_W-1:0] weight_sum;
  logic signed [SUM_W-1:0] factor_sum [LANES];
  logic        [SQR_W-1:0] square_sum [LANES];

  // Scores of finished samples that have not come out yet, oldest first.
  logic signed [OUT_W-1:0] score_q [$];
  logic signed [IN_W-1:0]  node_factor [LANES];
  int unsigned             fails;

  function automatic void clear_sums();
    weight_sum = '0;
    for (int f = 0; f < LANES; f++) begin
      factor_sum[f] = '0;
      square_sum[f] = '0;
    end
  endfunction

  // Add one node to the sums; lanes at DIM and above are ignored.
  function automatic void add_node();
    logic signed [PROD_W-1:0] prod;
    weight_sum = weight_sum + SUM_W'(node_i.node_weight);
    for (int f = 0; f < DIM; f++) begin
      prod          = node_factor[f] * node_factor[f];
      factor_sum[f] = factor_sum[f] + SUM_W'(node_factor[f]);
      square_sum[f] = square_sum[f] + SQR_W'(prod);
    end
  endfunction

  // Weight sum in Q.24 plus half the summed pair terms, floored and saturated.
  function automatic logic signed [OUT_W-1:0] sample_score();
    longint pair_total;
    longint lane_sum;
    longint total;
    pair_total = 0;
    for (int f = 0; f < DIM; f++) begin
      lane_sum   = longint'(factor_sum[f]);
      pair_total = pair_total + lane_sum * lane_sum - longint'({1'b0, square_sum[f]});
    end
    total = longint'(weight_sum) * (64'sd1 <<< FRAC_W) + (pair_total >>> 1);
    if (total > SCORE_MAX) total = SCORE_MAX;
    if (total < SCORE_MIN) total = SCORE_MIN;
    return OUT_W'(total);
  endfunction

  function automatic void report(string what, logic signed [OUT_W-1:0] want,
                                 logic signed [OUT_W-1:0] got);
    if (fails < 10) begin
      $display("%t: %s: expected %0d, got %0d", $realtime, what, want, got);
    end
    fails++;
  endfunction

  assign node_factor[0] = node_i.factor_0;
  assign node_factor[1] = node_i.factor_1;
  assign node_factor[2] = node_i.factor_2;
  assign node_factor[3] = node_i.factor_3;
  assign node_factor[4] = node_i.factor_4;
  assign node_factor[5] = node_i.factor_5;
  assign node_factor[6] = node_i.factor_6;
  assign node_factor[7] = node_i.factor_7;

  // Compare each score request with the oldest prediction, then fold in new nodes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sums();
      score_q.delete();
      fails = 0;
      fail_count_o <= 0;
      scores_due_o <= 0;
    end else begin
      if (score_i.valid && score_i.ready) begin
        if (score_q.size() == 0) begin
          report("score with no sample finished", '0, score_i.score);
        end else if (score_i.score !== score_q[0]) begin
          report("score mismatch", score_q[0], score_i.score);
          void'(score_q.pop_front());
        end else begin
          void'(score_q.pop_front());
        end
      end
      if (node_i.valid && node_i.ready) begin
        add_node();
        if (node_i.last_node) begin
          score_q = {score_q, sample_score()};
          clear_sums();
        end
      end
      fail_count_o <= fails;
      scores_due_o <= $unsigned(score_q.size());
    end
  end

endmodule

// File: sim/fm_second_order_score_core_tb.sv
// Testbench top: drives node requests and score ready, and gives the verdict.
`timescale 1ns / 1ps
module fm_second_order_score_core_tb;
  import fmss_pkg::*;

  typedef enum logic [1:0] {
    STYLE_MIXED,
    STYLE_EXTREME,
    STYLE_NEAR_MAX
  } value_style_e;

  typedef struct packed {
    logic                       last;
    logic [LANES-1:0][IN_W-1:0] factor;
    logic [IN_W-1:0]            weight;
  } node_req_t;

  localparam int unsigned ITEM_TARGET = 1450;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned scores_due;
  int unsigned items_sent;
  bit          steady;

  fmss_node_if  node_if ();
  fmss_score_if score_if ();

  fm_second_order_score_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .node_i  (node_if),
    .score_o (score_if)
  );

  fm_second_order_score_checker u_score_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_i       (node_if),
    .score_i      (score_if),
    .fail_count_o (fail_count),
    .scores_due_o (scores_due)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Field value generator: corner values, near full-scale positive values, small values and full-range noise.
  function automatic logic [IN_W-1:0] draw_value(value_style_e style);
    logic [IN_W-1:0] v;
    case (style)
      STYLE_EXTREME: begin
        case ($urandom_range(0, 2))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          default: v = 16'h8001;
        endcase
      end
      STYLE_NEAR_MAX: begin
        v = IN_W'($urandom_range(32300, 32767));
      end
      default: begin
        case ($urandom_range(0, 9))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'h0000;
          3:       v = 16'hFFFF;
          4, 5:    v = IN_W'($urandom_range(0, 511)) - 16'd256;
          default: v = IN_W'($urandom);
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic node_req_t uniform_req(logic [IN_W-1:0] w, logic [IN_W-1:0] f,
                                            logic last);
    node_req_t req;
    req.weight = w;
    req.last   = last;
    for (int k = 0; k < LANES; k++) req.factor[k] = f;
    return req;
  endfunction

  // Present one node request after a random gap (none in steady stretches) and hold it until accepted.
  task automatic send_node(input node_req_t req);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      node_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    node_if.valid       <= 1'b1;
    node_if.node_weight <= req.weight;
    node_if.factor_0    <= req.factor[0];
    node_if.factor_1    <= req.factor[1];
    node_if.factor_2    <= req.factor[2];
    node_if.factor_3    <= req.factor[3];
    node_if.factor_4    <= req.factor[4];
    node_if.factor_5    <= req.factor[5];
    node_if.factor_6    <= req.factor[6];
    node_if.factor_7    <= req.factor[7];
    node_if.last_node   <= req.last;
    @(posedge clk_i);
    while (!node_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_sample(input int unsigned nodes, input value_style_e style);
    node_req_t req;
    for (int unsigned k = 0; k < nodes; k++) begin
      req.weight = draw_value(style);
      for (int f = 0; f < LANES; f++) req.factor[f] = draw_value(style);
      req.last = (k == nodes - 1);
      send_node(req);
    end
  endtask

  // Stop sending and wait until every finished sample has been scored.
  task automatic drain_scores();
    node_if.valid <= 1'b0;
    @(posedge clk_i);
    while (scores_due != 0) @(posedge clk_i);
  endtask

  // Score receiver: random stall before each request, none in steady stretches.
  initial begin
    int unsigned gap;
    score_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        score_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      score_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!score_if.valid) @(posedge clk_i);
    end
  end

  // Stimulus: directed corners, long wrapping samples, then random samples.
  initial begin
    node_req_t req;
    int unsigned nodes;
    rst_ni     = 1'b0;
    steady     = 1'b0;
    items_sent = 0;
    node_if.valid       <= 1'b0;
    node_if.node_weight <= '0;
    node_if.factor_0    <= '0;
    node_if.factor_1    <= '0;
    node_if.factor_2    <= '0;
    node_if.factor_3    <= '0;
    node_if.factor_4    <= '0;
    node_if.factor_5    <= '0;
    node_if.factor_6    <= '0;
    node_if.factor_7    <= '0;
    node_if.last_node   <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-node samples at the extremes and at zero score just the node weight.
    send_node(uniform_req(16'h7FFF, 16'h7FFF, 1'b1));
    send_node(uniform_req(16'h8000, 16'h8000, 1'b1));
    send_node(uniform_req(16'h0000, 16'h0000, 1'b1));
    // Two nodes with opposite signs.
    send_node(uniform_req(16'hFFFF, 16'h0001, 1'b0));
    send_node(uniform_req(16'h0001, 16'hFFFF, 1'b1));
    // Two extreme nodes, then alternating bit patterns.
    send_node(uniform_req(16'h8000, 16'h7FFF, 1'b0));
    send_node(uniform_req(16'h7FFF, 16'h8000, 1'b0));
    send_node(uniform_req(16'h5555, 16'hAAAA, 1'b1));
    // Distinct values in every lane.
    req = uniform_req(16'hAAAA, 16'h0000, 1'b0);
    for (int f = 0; f < LANES; f++) req.factor[f] = IN_W'(f * 16'h2345) ^ 16'h8421;
    send_node(req);
    send_node(uniform_req(16'h5555, 16'h5555, 1'b0));
    req.last = 1'b1;
    send_node(req);
    drain_scores();

    // Near full-scale positive values: the sums wrap and the score saturates high.
    send_sample(MAX_NODES + 4, STYLE_NEAR_MAX);
    // Enough full-scale squares to wrap the square sums as well.
    send_sample(2 * MAX_NODES + 18, STYLE_EXTREME);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      if ($urandom_range(0, 15) == 0) nodes = $urandom_range(7, 40);
      else nodes = $urandom_range(1, 6);
      send_sample(nodes, ($urandom_range(0, 7) == 0) ? STYLE_EXTREME : STYLE_MIXED);
      if (items_sent > ITEM_TARGET / 2 && items_sent < ITEM_TARGET / 2 + 12) begin
        drain_scores();
      end
    end
    steady = 1'b0;

    drain_scores();
    repeat (NSTAGE + 4) @(posedge clk_i);
    if (fail_count == 0 && scores_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
